// ----- hdl/bqc_pkg.sv -----
// ----------------------------------------------------------------------------
// bqc_pkg: shared types and constants of the biquad cascade
// Register indexes, coefficient field positions, numerator codes, the
// section sequencer states and the control struct passed from cell to cell.
// ----------------------------------------------------------------------------
package bqc_pkg;

    // default parameter values
    localparam int MAX_SECTIONS_DEF = 6;
    localparam int STATE_BITS_DEF   = 40;
    localparam int SAMPLE_BITS_DEF  = 16;

    // configuration port
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int NUM_SECTION_REGS = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SECTION0_COEFFS  = 3'd0,
        REG_SECTION1_COEFFS  = 3'd1,
        REG_SECTION2_COEFFS  = 3'd2,
        REG_SECTION3_COEFFS  = 3'd3,
        REG_SECTION4_COEFFS  = 3'd4,
        REG_SECTION5_COEFFS  = 3'd5,
        REG_NUMERATOR_KIND   = 3'd6,
        REG_ACTIVE_SECTIONS  = 3'd7
    } reg_index_t;

    // coefficient word layout: a1 signed Q1.20, a2 and gain unsigned Q0.21
    localparam int A1_W    = 22;
    localparam int COEF_W  = 21;
    localparam int A1_LSB  = 42;
    localparam int A2_LSB  = 21;
    localparam int G_LSB   = 0;

    // fixed point: 8 fraction bits in the datapath, 21 in the coefficients
    localparam int FRAC_BITS  = 8;
    localparam int COEF_SHIFT = 21;

    // numerator forms; the unused code decodes as bandpass
    typedef enum logic [1:0] {
        NUM_BANDPASS = 2'd0,
        NUM_LOWPASS  = 2'd1,
        NUM_HIGHPASS = 2'd2
    } numerator_t;

    // per-section sequencer
    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_LO,
        CELL_HI,
        CELL_SUM,
        CELL_WSAT,
        CELL_OUT
    } cell_state_t;

    // control that travels beside a word from one section to the next
    typedef struct packed {
        logic valid;
        logic clip;
    } link_ctl_t;

endpackage

// ----- hdl/bqc_cell.sv -----
// ----------------------------------------------------------------------------
// bqc_cell: one second-order section of the cascade
// Holds its own two delays, multiplies with three narrow multipliers over two
// passes (low half, then high half of the state operands), accumulates, then
// saturates w and forms the numerator output for the next section.
// ----------------------------------------------------------------------------
module bqc_cell
    import bqc_pkg::*;
#(
    parameter int STATE_BITS = STATE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         active,
    input  logic [1:0]                   numerator_kind,
    input  logic [CFG_DATA_W-1:0]        coeffs,
    input  link_ctl_t                    in_ctl,
    input  logic signed [STATE_BITS-1:0] in_value,
    output link_ctl_t                    out_ctl,
    output logic signed [STATE_BITS-1:0] out_value
);

    localparam int LO_BITS = STATE_BITS / 2;
    localparam int HI_BITS = STATE_BITS - LO_BITS;
    localparam int OP_W    = HI_BITS + 1;
    localparam int CO_W    = A1_W + 1;
    localparam int PW      = OP_W + CO_W;
    localparam int SUM_W   = PW + 3;
    localparam int ACC_W   = STATE_BITS + 27;
    localparam int OUT_W   = STATE_BITS + 3;
    localparam logic signed [STATE_BITS-1:0] SAT_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0] SAT_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

    cell_state_t state_reg, state_next;

    logic signed [STATE_BITS-1:0] v_reg;
    logic                         clip_reg;
    logic signed [STATE_BITS-1:0] w1_reg, w2_reg, w_reg;
    logic signed [PW-1:0]         prod_v_reg, prod_a1_reg, prod_a2_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    link_ctl_t                    out_ctl_reg, out_ctl_next;
    logic signed [STATE_BITS-1:0] out_value_reg, out_value_next;

    logic signed [CO_W-1:0]       co_g, co_a1, co_a2;
    logic                         hi_sel;
    logic signed [OP_W-1:0]       op_v, op_w1, op_w2;
    logic signed [SUM_W-1:0]      sum_w;
    logic signed [ACC_W-1:0]      acc_sh;
    logic [ACC_W-STATE_BITS:0]    acc_top;
    logic                         w_fits;
    logic signed [STATE_BITS-1:0] w_next;
    logic signed [OUT_W-1:0]      o_full;
    logic [3:0]                   o_top;
    logic                         o_fits;
    logic signed [STATE_BITS-1:0] o_sat;

    // half of a state word as a signed multiplier operand
    function automatic logic signed [OP_W-1:0] half_of(
        input logic [STATE_BITS-1:0] x,
        input logic                  hi
    );
        logic [OP_W-1:0] r;
        if (hi) begin
            r = {x[STATE_BITS-1], x[STATE_BITS-1:LO_BITS]};
        end else begin
            r = {{(OP_W-LO_BITS){1'b0}}, x[LO_BITS-1:0]};
        end
        return $signed(r);
    endfunction

    // coefficient fields widened to one signed operand width
    assign co_g  = $signed({2'b00, coeffs[G_LSB +: COEF_W]});
    assign co_a2 = $signed({2'b00, coeffs[A2_LSB +: COEF_W]});
    assign co_a1 = $signed({coeffs[A1_LSB+A1_W-1], coeffs[A1_LSB +: A1_W]});

    // operand halves: low pass first, then high pass
    assign hi_sel = (state_reg == CELL_HI);
    assign op_v   = half_of(v_reg, hi_sel);
    assign op_w1  = half_of(w1_reg, hi_sel);
    assign op_w2  = half_of(w2_reg, hi_sel);

    // v*g - 2*w1*a1 - w2*a2 for one half
    assign sum_w = SUM_W'(prod_v_reg) - (SUM_W'(prod_a1_reg) <<< 1) - SUM_W'(prod_a2_reg);

    // w = floor(acc / 2^21), saturated
    assign acc_sh  = acc_reg >>> COEF_SHIFT;
    assign acc_top = acc_sh[ACC_W-1:STATE_BITS-1];
    assign w_fits  = (&acc_top) | (~|acc_top);
    assign w_next  = w_fits ? acc_sh[STATE_BITS-1:0] : (acc_sh[ACC_W-1] ? SAT_MIN : SAT_MAX);

    // numerator output
    always_comb begin
        case (numerator_kind)
            NUM_LOWPASS:  o_full = OUT_W'(w_reg) + (OUT_W'(w1_reg) <<< 1) + OUT_W'(w2_reg);
            NUM_HIGHPASS: o_full = OUT_W'(w_reg) - (OUT_W'(w1_reg) <<< 1) + OUT_W'(w2_reg);
            default:      o_full = OUT_W'(w_reg) - OUT_W'(w2_reg);
        endcase
    end

    assign o_top  = o_full[OUT_W-1:STATE_BITS-1];
    assign o_fits = (&o_top) | (~|o_top);
    assign o_sat  = o_fits ? o_full[STATE_BITS-1:0] : (o_full[OUT_W-1] ? SAT_MIN : SAT_MAX);

    // sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CELL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and hand-off to the next section
    always_comb begin
        state_next     = state_reg;
        out_ctl_next   = '0;
        out_value_next = out_value_reg;
        case (state_reg)
            CELL_IDLE: begin
                if (in_ctl.valid) begin
                    if (active) begin
                        state_next = CELL_LO;
                    end else begin
                        out_ctl_next   = in_ctl;
                        out_value_next = in_value;
                    end
                end
            end
            CELL_LO:   state_next = CELL_HI;
            CELL_HI:   state_next = CELL_SUM;
            CELL_SUM:  state_next = CELL_WSAT;
            CELL_WSAT: state_next = CELL_OUT;
            CELL_OUT: begin
                state_next         = CELL_IDLE;
                out_ctl_next.valid = 1'b1;
                out_ctl_next.clip  = clip_reg | ~o_fits;
                out_value_next     = o_sat;
            end
            default:   state_next = CELL_IDLE;
        endcase
    end

    // delays
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w1_reg <= '0;
            w2_reg <= '0;
        end else if (state_reg == CELL_OUT) begin
            w2_reg <= w1_reg;
            w1_reg <= w_reg;
        end
    end

    // link control to the next section
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_ctl_reg <= '0;
        end else begin
            out_ctl_reg <= out_ctl_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        out_value_reg <= out_value_next;
        case (state_reg)
            CELL_IDLE: begin
                v_reg    <= in_value;
                clip_reg <= in_ctl.clip;
            end
            CELL_LO, CELL_HI: begin
                prod_v_reg  <= op_v * co_g;
                prod_a1_reg <= op_w1 * co_a1;
                prod_a2_reg <= op_w2 * co_a2;
                if (state_reg == CELL_HI) begin
                    acc_reg <= ACC_W'(sum_w);
                end
            end
            CELL_SUM: begin
                acc_reg <= acc_reg + (ACC_W'(sum_w) <<< LO_BITS);
            end
            CELL_WSAT: begin
                w_reg    <= w_next;
                clip_reg <= clip_reg | ~w_fits;
            end
            default: begin
                w_reg <= w_reg;
            end
        endcase
    end

    assign out_ctl   = out_ctl_reg;
    assign out_value = out_value_reg;

endmodule

// ----- hdl/biquad_cascade_iir_filter.sv -----
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter: cascade of Direct Form II biquad sections
// A row of section cells carries each sample down the cascade; the top level
// holds the configuration registers and the input and output registers.
// ----------------------------------------------------------------------------
// One sample is in the cascade at a time. The input register loads on the
// accepting edge. In each active section the sample then passes through a
// capture, two multiply passes with three multipliers, an accumulate, a
// saturate and an output step in that section's cell; a bypassed section
// passes it on through its output register, and the final shift and
// saturate then fill the holding and output registers. The
// next sample is taken as soon as the result has moved to the output
// register, while that result still waits on m_tready. Coefficients use
// a1 in bits 63:42 (signed Q1.20), a2 in 41:21 and gain in 20:0 (unsigned
// Q0.21); write them only while the filter holds no sample.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_filter
    import bqc_pkg::*;
#(
    parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
    parameter int STATE_BITS   = STATE_BITS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input samples
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,   // sample
    // filtered samples
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // filtered_sample
    output logic [0:0]             m_tuser,   // clipped
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int FIN_W = (STATE_BITS > SAMPLE_BITS + FRAC_BITS) ?
                           STATE_BITS : SAMPLE_BITS + FRAC_BITS;
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [1:0]                   numerator_kind_reg;
    logic [2:0]                   active_sections_reg;
    logic [CFG_DATA_W-1:0]        section_coeffs [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0]      section_active;

    logic                         busy_reg;
    link_ctl_t                    link_ctl_reg;
    logic signed [STATE_BITS-1:0] link_value_reg;
    link_ctl_t                    chain_ctl   [MAX_SECTIONS+1];
    logic signed [STATE_BITS-1:0] chain_value [MAX_SECTIONS+1];

    logic                         fin_valid_reg;
    logic [SAMPLE_BITS-1:0]       fin_sample_reg;
    logic                         fin_clip_reg;
    logic                         m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]       m_sample_reg;
    logic                         m_clip_reg;

    logic                         in_fire, cfg_fire, move_out;
    logic signed [FIN_W-1:0]      fin_sh;
    logic [FIN_W-SAMPLE_BITS:0]   fin_top;
    logic                         fin_fits;
    logic [SAMPLE_BITS-1:0]       fin_next;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign s_tready  = ~busy_reg;
    assign in_fire   = s_tvalid & s_tready;

    // global registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            numerator_kind_reg  <= NUM_BANDPASS;
            active_sections_reg <= 3'd6;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_NUMERATOR_KIND:  numerator_kind_reg  <= cfg_data[1:0];
                REG_ACTIVE_SECTIONS: active_sections_reg <= cfg_data[2:0];
                default:             numerator_kind_reg  <= numerator_kind_reg;
            endcase
        end
    end

    // per-section coefficient registers and the cell row
    for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_sec
        if (i < NUM_SECTION_REGS) begin : g_coef
            logic [CFG_DATA_W-1:0] coeff_reg;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    coeff_reg <= '0;
                end else if (cfg_fire && cfg_index == CFG_INDEX_W'(i)) begin
                    coeff_reg <= cfg_data;
                end
            end
            assign section_coeffs[i] = coeff_reg;
        end else begin : g_nocoef
            assign section_coeffs[i] = '0;
        end

        // a count of zero still runs the first section
        assign section_active[i] = (i == 0) || (int'(active_sections_reg) > i);

        bqc_cell #(
            .STATE_BITS (STATE_BITS)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .active         (section_active[i]),
            .numerator_kind (numerator_kind_reg),
            .coeffs         (section_coeffs[i]),
            .in_ctl         (chain_ctl[i]),
            .in_value       (chain_value[i]),
            .out_ctl        (chain_ctl[i+1]),
            .out_value      (chain_value[i+1])
        );
    end

    assign chain_ctl[0]   = link_ctl_reg;
    assign chain_value[0] = link_value_reg;

    // input register: sample scaled to 8 fraction bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_ctl_reg <= '0;
        end else begin
            link_ctl_reg.valid <= in_fire;
            link_ctl_reg.clip  <= 1'b0;
        end
        if (in_fire) begin
            link_value_reg <= STATE_BITS'($signed({s_tdata[SAMPLE_BITS-1:0],
                                                   {FRAC_BITS{1'b0}}}));
        end
    end

    // final shift and saturate to sample width
    assign fin_sh   = FIN_W'(chain_value[MAX_SECTIONS]) >>> FRAC_BITS;
    assign fin_top  = fin_sh[FIN_W-1:SAMPLE_BITS-1];
    assign fin_fits = (&fin_top) | (~|fin_top);
    assign fin_next = fin_fits ? fin_sh[SAMPLE_BITS-1:0] :
                      (fin_sh[FIN_W-1] ? OUT_MIN : OUT_MAX);

    assign move_out = fin_valid_reg & (~m_tvalid_reg | m_tready);

    // busy from accept until the result reaches the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (in_fire) begin
                busy_reg <= 1'b1;
            end else if (move_out) begin
                busy_reg <= 1'b0;
            end
            if (chain_ctl[MAX_SECTIONS].valid) begin
                fin_valid_reg <= 1'b1;
            end else if (move_out) begin
                fin_valid_reg <= 1'b0;
            end
            if (move_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result holding and output registers
    always_ff @(posedge aclk) begin
        if (chain_ctl[MAX_SECTIONS].valid) begin
            fin_sample_reg <= fin_next;
            fin_clip_reg   <= chain_ctl[MAX_SECTIONS].clip | ~fin_fits;
        end
        if (move_out) begin
            m_sample_reg <= fin_sample_reg;
            m_clip_reg   <= fin_clip_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_sample_reg);
    assign m_tuser  = m_clip_reg;

`ifndef SYNTHESIS
    // one sample at a time: accepting closes the input
    a_accept_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("input still open after accepting a word");

    // a cascade result only appears while a sample is in flight
    a_result_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_ctl[MAX_SECTIONS].valid |-> busy_reg)
        else $error("cascade result without a sample in flight");

    // a cascade result never overwrites a pending one
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_ctl[MAX_SECTIONS].valid |-> !fin_valid_reg)
        else $error("cascade result arrived while previous one pending");

    // the cascade input pulse lasts one cycle
    a_link_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        link_ctl_reg.valid |=> !link_ctl_reg.valid)
        else $error("section input pulse longer than one cycle");
`endif

endmodule
